// ===== src/lens_distort_undistort_point_macros.svh =====
// Assertion macros shared by the lens point checker.
`ifndef LENS_DISTORT_UNDISTORT_POINT_MACROS_SVH
`define LENS_DISTORT_UNDISTORT_POINT_MACROS_SVH

// Implication checked while out of reset.
`define LDUP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define LDUP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ldup_pkg.sv =====
// Types, constants and fixed-point helpers for the lens point pipeline.
package ldup_pkg;

    localparam int DIV_LAT  = 33;
    localparam int PASS_LAT = 9 + DIV_LAT + 2;
    localparam int ADDR_W   = 6;

    localparam logic [2:0] REG_FOCAL  = 3'd0;
    localparam logic [2:0] REG_PP     = 3'd1;
    localparam logic [2:0] REG_K1     = 3'd2;
    localparam logic [2:0] REG_K2     = 3'd3;
    localparam logic [2:0] REG_P1     = 3'd4;
    localparam logic [2:0] REG_P2     = 3'd5;
    localparam logic [2:0] REG_K3     = 3'd6;
    localparam logic [2:0] REG_ENABLE = 3'd7;

    localparam logic [63:0] FOCAL_RESET = 64'h0001_0000_0001_0000;
    localparam logic [63:0] RECIP_NUM   = 64'd1 << 48;
    localparam logic signed [65:0] ONE_Q24 = 66'sd1 <<< 24;

    typedef struct packed {
        logic               op;
        logic               done;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] x0;
        logic signed [31:0] y0;
    } t_item;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } t_coef;

    function automatic logic signed [65:0] sx(input logic signed [31:0] v);
        return 66'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fff_ffff;
        if (v < -66'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // round to nearest, ties up: floor((p + half) / 2^s)
    function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] p,
                                                  input int unsigned s);
        return (p + (66'sd1 <<< (s - 1))) >>> s;
    endfunction

endpackage

// ===== src/ldup_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, saturated signed result.
module ldup_div #(
    parameter int PW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [63:0]         i_num,
    input  logic [31:0]         i_den,
    input  logic                i_neg,
    input  logic [PW-1:0]       i_pl,
    output logic                o_valid,
    output logic signed [31:0]  o_q,
    output logic [PW-1:0]       o_pl
);
    localparam int QB = 31;

    logic          r_v   [0:QB];
    logic [63:0]   r_rem [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic [31:0]   r_den [0:QB];
    logic          r_neg [0:QB];
    logic          r_ovf [0:QB];
    logic [PW-1:0] r_pl  [0:QB];

    logic               r_ov;
    logic signed [31:0] r_oq;
    logic [PW-1:0]      r_opl;

    // quotient magnitude of 2^31 or more saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= i_num;
        r_q[0]   <= '0;
        r_den[0] <= i_den;
        r_neg[0] <= i_neg;
        r_ovf[0] <= i_num >= (64'(i_den) << QB);
        r_pl[0]  <= i_pl;
    end

    for (genvar s = 1; s <= QB; s++) begin : g_stage
        logic [63:0] n_sub;
        logic        n_hit;
        always_comb begin
            n_sub = 64'(r_den[s-1]) << (QB - s);
            n_hit = r_rem[s-1] >= n_sub;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= r_v[s-1];
            end
            r_rem[s] <= n_hit ? r_rem[s-1] - n_sub : r_rem[s-1];
            r_q[s]   <= r_q[s-1] | (QB'(n_hit) << (QB - s));
            r_den[s] <= r_den[s-1];
            r_neg[s] <= r_neg[s-1];
            r_ovf[s] <= r_ovf[s-1];
            r_pl[s]  <= r_pl[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[QB];
        end
        if (r_ovf[QB]) begin
            r_oq <= r_neg[QB] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r_oq <= r_neg[QB] ? -$signed({1'b0, r_q[QB]}) : $signed({1'b0, r_q[QB]});
        end
        r_opl <= r_pl[QB];
    end

    assign o_valid = r_ov;
    assign o_q     = r_oq;
    assign o_pl    = r_opl;

endmodule

// ===== src/ldup_pass.sv =====
// One pass of the lens model: radial factor, tangential terms, reciprocal and update.
module ldup_pass (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ldup_pkg::t_item i_item,
    input  ldup_pkg::t_coef i_coef,
    output logic           o_valid,
    output ldup_pkg::t_item o_item
);
    typedef struct packed {
        ldup_pkg::t_item    it;
        logic signed [31:0] cd;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } t_tail;

    // P1: squares and cross product
    logic r1_v;  ldup_pkg::t_item r1_it;
    logic signed [63:0] r1_xx, r1_yy, r1_xy;
    // P2: rounded Q4.28
    logic r2_v;  ldup_pkg::t_item r2_it;
    logic signed [31:0] r2_xx, r2_yy, r2_xy;
    // P3: r2 and tangential arguments
    logic r3_v;  ldup_pkg::t_item r3_it;
    logic signed [31:0] r3_r2, r3_a, r3_b, r3_xy;
    // P4: first products
    logic r4_v;  ldup_pkg::t_item r4_it;
    logic signed [31:0] r4_r2;
    logic signed [63:0] r4_m3, r4_mp1, r4_mp2, r4_mq1, r4_mq2;
    // P5
    logic r5_v;  ldup_pkg::t_item r5_it;
    logic signed [31:0] r5_r2, r5_t, r5_dx, r5_dy;
    // P6
    logic r6_v;  ldup_pkg::t_item r6_it;
    logic signed [31:0] r6_r2, r6_dx, r6_dy, r6_ex, r6_ey;
    logic signed [63:0] r6_m;
    // P7
    logic r7_v;  ldup_pkg::t_item r7_it;
    logic signed [31:0] r7_r2, r7_t, r7_dx, r7_dy, r7_ex, r7_ey;
    // P8
    logic r8_v;  ldup_pkg::t_item r8_it;
    logic signed [63:0] r8_m;
    logic signed [31:0] r8_dx, r8_dy, r8_ex, r8_ey;
    // P9: radial factor
    logic r9_v;  t_tail r9_tl;
    // after reciprocal
    logic  d_v;
    logic signed [31:0] d_icd;
    t_tail d_tl;
    logic [$bits(t_tail)-1:0] d_pl;
    logic [31:0] n_mag;
    // A: final products
    logic ra_v;  t_tail ra_tl;
    logic signed [63:0] ra_ux, ra_uy, ra_dx, ra_dy;
    // B: result
    logic rb_v;  ldup_pkg::t_item rb_it;

    logic signed [31:0] n_r2;
    ldup_pkg::t_item    n_it;

    always_comb begin
        n_r2 = ldup_pkg::sat32(ldup_pkg::sx(r2_xx) + ldup_pkg::sx(r2_yy));
        n_mag = r9_tl.cd[31] ? 32'(-ldup_pkg::sx(r9_tl.cd)) : 32'(r9_tl.cd);
        d_tl = t_tail'(d_pl);
        n_it = ra_tl.it;
        if (!ra_tl.it.done) begin
            if (ra_tl.it.op) begin
                n_it.x = ldup_pkg::sat32(ldup_pkg::rnd_sh(ra_ux, 24));
                n_it.y = ldup_pkg::sat32(ldup_pkg::rnd_sh(ra_uy, 24));
            end else begin
                n_it.x = ldup_pkg::sat32(ldup_pkg::sx(ldup_pkg::sat32(
                             ldup_pkg::rnd_sh(ra_dx, 24))) + ldup_pkg::sx(ra_tl.dx));
                n_it.y = ldup_pkg::sat32(ldup_pkg::sx(ldup_pkg::sat32(
                             ldup_pkg::rnd_sh(ra_dy, 24))) + ldup_pkg::sx(ra_tl.dy));
            end
        end
        // a distorted point is final after its first pass
        n_it.done = ra_tl.it.done | ~ra_tl.it.op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0; r5_v <= 1'b0;
            r6_v <= 1'b0; r7_v <= 1'b0; r8_v <= 1'b0; r9_v <= 1'b0;
            ra_v <= 1'b0; rb_v <= 1'b0;
        end else begin
            r1_v <= i_valid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v; r5_v <= r4_v;
            r6_v <= r5_v; r7_v <= r6_v; r8_v <= r7_v; r9_v <= r8_v;
            ra_v <= d_v; rb_v <= ra_v;
        end

        r1_it <= i_item;
        r1_xx <= i_item.x * i_item.x;
        r1_yy <= i_item.y * i_item.y;
        r1_xy <= i_item.x * i_item.y;

        r2_it <= r1_it;
        r2_xx <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r1_xx, 28));
        r2_yy <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r1_yy, 28));
        r2_xy <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r1_xy, 28));

        r3_it <= r2_it;
        r3_r2 <= n_r2;
        r3_a  <= ldup_pkg::sat32(ldup_pkg::sx(n_r2) + (ldup_pkg::sx(r2_xx) <<< 1));
        r3_b  <= ldup_pkg::sat32(ldup_pkg::sx(n_r2) + (ldup_pkg::sx(r2_yy) <<< 1));
        r3_xy <= r2_xy;

        r4_it  <= r3_it;
        r4_r2  <= r3_r2;
        r4_m3  <= i_coef.k3 * r3_r2;
        r4_mp1 <= i_coef.p1 * r3_xy;
        r4_mp2 <= i_coef.p2 * r3_a;
        r4_mq1 <= i_coef.p1 * r3_b;
        r4_mq2 <= i_coef.p2 * r3_xy;

        r5_it <= r4_it;
        r5_r2 <= r4_r2;
        r5_t  <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r4_m3, 28) + ldup_pkg::sx(i_coef.k2));
        r5_dx <= ldup_pkg::sat32(
                     (ldup_pkg::sx(ldup_pkg::sat32(ldup_pkg::rnd_sh(r4_mp1, 24))) <<< 1)
                     + ldup_pkg::sx(ldup_pkg::sat32(ldup_pkg::rnd_sh(r4_mp2, 24))));
        r5_dy <= ldup_pkg::sat32(
                     ldup_pkg::sx(ldup_pkg::sat32(ldup_pkg::rnd_sh(r4_mq1, 24)))
                     + (ldup_pkg::sx(ldup_pkg::sat32(ldup_pkg::rnd_sh(r4_mq2, 24))) <<< 1));

        r6_it <= r5_it;
        r6_r2 <= r5_r2;
        r6_m  <= r5_t * r5_r2;
        r6_dx <= r5_dx;
        r6_dy <= r5_dy;
        r6_ex <= ldup_pkg::sat32(ldup_pkg::sx(r5_it.x0) - ldup_pkg::sx(r5_dx));
        r6_ey <= ldup_pkg::sat32(ldup_pkg::sx(r5_it.y0) - ldup_pkg::sx(r5_dy));

        r7_it <= r6_it;
        r7_r2 <= r6_r2;
        r7_t  <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r6_m, 28) + ldup_pkg::sx(i_coef.k1));
        r7_dx <= r6_dx; r7_dy <= r6_dy; r7_ex <= r6_ex; r7_ey <= r6_ey;

        r8_it <= r7_it;
        r8_m  <= r7_t * r7_r2;
        r8_dx <= r7_dx; r8_dy <= r7_dy; r8_ex <= r7_ex; r8_ey <= r7_ey;

        r9_tl.it <= r8_it;
        r9_tl.cd <= ldup_pkg::sat32(ldup_pkg::rnd_sh(r8_m, 28) + ldup_pkg::ONE_Q24);
        r9_tl.dx <= r8_dx; r9_tl.dy <= r8_dy; r9_tl.ex <= r8_ex; r9_tl.ey <= r8_ey;

        ra_tl <= d_tl;
        ra_ux <= d_tl.ex * d_icd;
        ra_uy <= d_tl.ey * d_icd;
        ra_dx <= d_tl.it.x0 * d_tl.cd;
        ra_dy <= d_tl.it.y0 * d_tl.cd;

        rb_it <= n_it;
    end

    // zero radial factor: numerator >= 0 flags overflow, giving the positive limit
    ldup_div #(
        .PW ($bits(t_tail))
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r9_v),
        .i_num   (ldup_pkg::RECIP_NUM),
        .i_den   (n_mag),
        .i_neg   (r9_tl.cd[31]),
        .i_pl    (r9_tl),
        .o_valid (d_v),
        .o_q     (d_icd),
        .o_pl    (d_pl)
    );

    assign o_valid = rb_v;
    assign o_item  = rb_it;

endmodule

// ===== src/lens_distort_undistort_point.sv =====
// Throughput: one point per cycle; busy never rises and results are never held.
// Each pass is 9 arithmetic stages, a 33-stage reciprocal divider and 2 update stages;
// normalization runs x and y through their own copies of the 33-stage divider, behind one input stage.
// Synchronous active-low reset clears all valid bits and restores the register defaults.
module lens_distort_undistort_point #(
    parameter int UNDISTORT_PASSES = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic signed [31:0]            i_x_in,
    input  logic signed [31:0]            i_y_in,
    output logic                          o_valid,
    output logic signed [31:0]            o_x_out,
    output logic signed [31:0]            o_y_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ldup_pkg::ADDR_W-1:0]   paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    localparam int DL = ldup_pkg::PASS_LAT * UNDISTORT_PASSES;

    logic [63:0]        r_focal, r_pp;
    logic signed [31:0] r_k1, r_k2, r_k3, r_p1, r_p2;
    logic               r_en;

    logic [2:0]         n_idx;
    logic               n_wr;
    ldup_pkg::t_coef    n_coef;
    logic [31:0]        n_fx, n_fy;
    logic signed [31:0] n_cx, n_cy;
    logic signed [65:0] n_dx, n_dy;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign n_idx  = paddr[ldup_pkg::ADDR_W-1:3];
    assign n_wr   = psel & penable & pwrite;
    assign n_fx   = r_focal[31:0];
    assign n_fy   = r_focal[63:32];
    assign n_cx   = r_pp[31:0];
    assign n_cy   = r_pp[63:32];
    assign n_coef = '{k1: r_k1, k2: r_k2, k3: r_k3, p1: r_p1, p2: r_p2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= ldup_pkg::FOCAL_RESET;
            r_pp    <= '0;
            r_k1    <= '0;
            r_k2    <= '0;
            r_p1    <= '0;
            r_p2    <= '0;
            r_k3    <= '0;
            r_en    <= 1'b0;
        end else if (n_wr) begin
            unique case (n_idx)
                ldup_pkg::REG_FOCAL:  r_focal <= pwdata;
                ldup_pkg::REG_PP:     r_pp    <= pwdata;
                ldup_pkg::REG_K1:     r_k1    <= pwdata[31:0];
                ldup_pkg::REG_K2:     r_k2    <= pwdata[31:0];
                ldup_pkg::REG_P1:     r_p1    <= pwdata[31:0];
                ldup_pkg::REG_P2:     r_p2    <= pwdata[31:0];
                ldup_pkg::REG_K3:     r_k3    <= pwdata[31:0];
                ldup_pkg::REG_ENABLE: r_en    <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            ldup_pkg::REG_FOCAL:  prdata = r_focal;
            ldup_pkg::REG_PP:     prdata = r_pp;
            ldup_pkg::REG_K1:     prdata = {32'd0, r_k1};
            ldup_pkg::REG_K2:     prdata = {32'd0, r_k2};
            ldup_pkg::REG_P1:     prdata = {32'd0, r_p1};
            ldup_pkg::REG_P2:     prdata = {32'd0, r_p2};
            ldup_pkg::REG_K3:     prdata = {32'd0, r_k3};
            ldup_pkg::REG_ENABLE: prdata = {63'd0, r_en};
        endcase
    end

    // input stage: offset from principal point, magnitude and sign
    logic               r_t1_v, r_t1_op, r_t1_byp, r_t1_nx, r_t1_ny;
    logic [32:0]        r_t1_mx, r_t1_my;
    logic signed [31:0] r_t1_px, r_t1_py;

    always_comb begin
        n_dx = ldup_pkg::sx(i_x_in) - ldup_pkg::sx(n_cx);
        n_dy = ldup_pkg::sx(i_y_in) - ldup_pkg::sx(n_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_v <= 1'b0;
        end else begin
            r_t1_v <= start & ~busy;
        end
        r_t1_op  <= i_op;
        r_t1_byp <= ~r_en | (n_fx == 32'd0) | (n_fy == 32'd0);
        r_t1_px  <= i_x_in;
        r_t1_py  <= i_y_in;
        r_t1_nx  <= n_dx[65];
        r_t1_ny  <= n_dy[65];
        r_t1_mx  <= n_dx[65] ? 33'(-n_dx) : 33'(n_dx);
        r_t1_my  <= n_dy[65] ? 33'(-n_dy) : 33'(n_dy);
    end

    logic               u_vx, u_vy, u_op;
    logic signed [31:0] u_qx, u_qy;
    logic [64:0]        u_bp;

    ldup_div #(
        .PW (1)
    ) u_norm_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t1_v),
        .i_num   (64'({r_t1_mx, 28'd0})),
        .i_den   (n_fx),
        .i_neg   (r_t1_nx),
        .i_pl    (r_t1_op),
        .o_valid (u_vx),
        .o_q     (u_qx),
        .o_pl    (u_op)
    );

    ldup_div #(
        .PW (65)
    ) u_norm_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_t1_v),
        .i_num   (64'({r_t1_my, 28'd0})),
        .i_den   (n_fy),
        .i_neg   (r_t1_ny),
        .i_pl    ({r_t1_byp, r_t1_px, r_t1_py}),
        .o_valid (u_vy),
        .o_q     (u_qy),
        .o_pl    (u_bp)
    );

    logic            s_v    [0:UNDISTORT_PASSES];
    ldup_pkg::t_item s_item [0:UNDISTORT_PASSES];

    assign s_v[0]    = u_vx & u_vy;
    assign s_item[0] = '{op: u_op, done: 1'b0, x: u_qx, y: u_qy, x0: u_qx, y0: u_qy};

    for (genvar p = 0; p < UNDISTORT_PASSES; p++) begin : g_pass
        ldup_pass u_pass (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_v[p]),
            .i_item  (s_item[p]),
            .i_coef  (n_coef),
            .o_valid (s_v[p+1]),
            .o_item  (s_item[p+1])
        );
    end

    // pass-through point and bypass flag, aligned with the pass chain
    logic [64:0] r_dl [0:DL-1];

    always_ff @(posedge i_clk) begin
        r_dl[0] <= u_bp;
        for (int k = 1; k < DL; k++) begin
            r_dl[k] <= r_dl[k-1];
        end
    end

    logic               r_o1_v, r_o1_byp;
    logic signed [64:0] r_o1_mx, r_o1_my;
    logic signed [31:0] r_o1_px, r_o1_py;
    logic               r_ov;
    logic signed [31:0] r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_v <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_o1_v <= s_v[UNDISTORT_PASSES];
            r_ov   <= r_o1_v;
        end
        r_o1_mx  <= $signed({1'b0, n_fx}) * s_item[UNDISTORT_PASSES].x;
        r_o1_my  <= $signed({1'b0, n_fy}) * s_item[UNDISTORT_PASSES].y;
        r_o1_byp <= r_dl[DL-1][64];
        r_o1_px  <= r_dl[DL-1][63:32];
        r_o1_py  <= r_dl[DL-1][31:0];

        r_ox <= r_o1_byp ? r_o1_px
              : ldup_pkg::sat32(ldup_pkg::rnd_sh(r_o1_mx, 28) + ldup_pkg::sx(n_cx));
        r_oy <= r_o1_byp ? r_o1_py
              : ldup_pkg::sat32(ldup_pkg::rnd_sh(r_o1_my, 28) + ldup_pkg::sx(n_cy));
    end

    assign o_valid = r_ov;
    assign o_x_out = r_ox;
    assign o_y_out = r_oy;

endmodule

// ===== src/ldup_chk.sv =====
// Port-level checker for the lens point block, bound to the top level.
`include "lens_distort_undistort_point_macros.svh"

module ldup_chk #(
    parameter int UNDISTORT_PASSES = 5
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic                        pready
);
    localparam int LAT = 3 + ldup_pkg::DIV_LAT + ldup_pkg::PASS_LAT * UNDISTORT_PASSES;

    `LDUP_ASSERT_IMP(a_result_has_request, o_valid, $past(start && !busy, LAT), "result without request")
    `LDUP_ASSERT_IMP(a_request_has_result, start && !busy, ##LAT o_valid, "request lost")
    `LDUP_ASSERT_IMP(a_never_busy, 1'b1, !busy && pready, "pipeline stalled")
    `LDUP_ASSERT_NEXT(a_reset_clears, !i_rst_n, !o_valid, "strobe after reset")

endmodule

bind lens_distort_undistort_point ldup_chk #(
    .UNDISTORT_PASSES (UNDISTORT_PASSES)
) u_ldup_chk (.*);
